// ----- sv/tpat_pkg.sv -----
package tpat_pkg;

	localparam int MAX_TRACKS = 16;
	localparam int MAX_PLOTS  = 32;
	localparam int ID_WIDTH   = 32;
	localparam int GAIN_WIDTH = 32;

	localparam int PORT_ID_W   = 32;
	localparam int PORT_GAIN_W = 32;
	localparam int PORT_TIDX_W = 4;
	localparam int PORT_PIDX_W = 5;

	localparam int GAIN_BITS = (GAIN_WIDTH < PORT_GAIN_W) ? GAIN_WIDTH : PORT_GAIN_W;
	localparam int TIDX_W    = $clog2(MAX_TRACKS);
	localparam int PIDX_W    = $clog2(MAX_PLOTS);
	localparam int TCNT_W    = $clog2(MAX_TRACKS + 1);
	localparam int PCNT_W    = $clog2(MAX_PLOTS + 1);
	localparam int CELLS     = MAX_TRACKS * MAX_PLOTS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int ENTRY_W   = GAIN_BITS + 1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [1:0] OP_ASSOC = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_MISS  = 2'd1;
	localparam logic [1:0] STAT_TFULL = 2'd2;
	localparam logic [1:0] STAT_PFULL = 2'd3;

	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_CLEAR = 2'd3;

	typedef struct packed {
		logic [1:0]           kind;
		logic [1:0]           status;
		logic [TIDX_W-1:0]    tidx;
		logic [PIDX_W-1:0]    pidx;
		logic [GAIN_BITS-1:0] gain;
		logic                 flag;
	} cmd_t;

	typedef struct packed {
		logic [PORT_TIDX_W-1:0] tidx;
		logic [PORT_PIDX_W-1:0] pidx;
		logic [1:0]             status;
		logic [PORT_GAIN_W-1:0] gain;
		logic                   flag;
	} res_t;

endpackage

// ----- sv/track_plot_association_table_core.sv -----
// Path: input stage, queue, then back end with registered result; reads add the read state.
// Throughput: one transaction per cycle for associate and ignored codes while busy is low.
// Clear all: a sweep over all 512 matrix entries, one entry per cycle, then the done strobe.
// Reset: counts cleared at once, then the same sweep with busy high throughout.
// The receiver cannot stall: each result shows for exactly one cycle with done high.
module track_plot_association_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          operation,
	input  logic [tpat_pkg::PORT_ID_W-1:0]      track_id,
	input  logic [tpat_pkg::PORT_ID_W-1:0]      plot_id,
	input  logic                                in_gate,
	input  logic [tpat_pkg::PORT_GAIN_W-1:0]    gain,
	output logic                                done,
	output logic [tpat_pkg::PORT_TIDX_W-1:0]    track_index,
	output logic [tpat_pkg::PORT_PIDX_W-1:0]    plot_index,
	output logic [1:0]                          status,
	output logic [tpat_pkg::PORT_GAIN_W-1:0]    gain_out,
	output logic                                in_gate_out
);

	import tpat_pkg::*;

	cmd_t q_in, q_head;
	res_t res;
	logic push, pop, q_full, q_avail, init_hold;

	tpat_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.hold      (init_hold),
		.operation (operation),
		.track_id  (track_id),
		.plot_id   (plot_id),
		.in_gate   (in_gate),
		.gain      (gain),
		.q_full    (q_full),
		.busy      (busy),
		.push      (push),
		.cmd       (q_in)
	);

	tpat_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_in),
		.pop    (pop),
		.dout   (q_head),
		.avail  (q_avail),
		.full   (q_full)
	);

	tpat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.avail     (q_avail),
		.head      (q_head),
		.pop       (pop),
		.init_hold (init_hold),
		.done      (done),
		.res       (res)
	);

	assign track_index = res.tidx;
	assign plot_index  = res.pidx;
	assign status      = res.status;
	assign gain_out    = res.gain;
	assign in_gate_out = res.flag;

endmodule

// ----- sv/tpat_ram.sv -----
module tpat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/tpat_front.sv -----
module tpat_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic                               hold,
	input  logic [1:0]                         operation,
	input  logic [tpat_pkg::PORT_ID_W-1:0]     track_id,
	input  logic [tpat_pkg::PORT_ID_W-1:0]     plot_id,
	input  logic                               in_gate,
	input  logic [tpat_pkg::PORT_GAIN_W-1:0]   gain,
	input  logic                               q_full,
	output logic                               busy,
	output logic                               push,
	output tpat_pkg::cmd_t                     cmd
);

	import tpat_pkg::*;

	logic                 valid_s1;
	logic [1:0]           op_s1;
	logic [ID_WIDTH-1:0]  tid_s1;
	logic [ID_WIDTH-1:0]  pid_s1;
	logic                 flag_s1;
	logic [GAIN_BITS-1:0] gain_s1;

	logic [TCNT_W-1:0]    track_count_q;
	logic [PCNT_W-1:0]    plot_count_q;
	logic [ID_WIDTH-1:0]  track_tab_q [MAX_TRACKS];
	logic [ID_WIDTH-1:0]  plot_tab_q [MAX_PLOTS];

	logic [MAX_TRACKS-1:0] t_hit;
	logic [MAX_PLOTS-1:0]  p_hit;
	logic [TIDX_W-1:0]     t_idx;
	logic [PIDX_W-1:0]     p_idx;
	logic                  t_miss, p_miss, t_full, p_full;
	logic                  t_ins, p_ins, cnt_clr;
	logic                  accept;

	always_comb begin
		t_idx = '0;
		for (int i = 0; i < MAX_TRACKS; i++) begin
			t_hit[i] = (TCNT_W'(i) < track_count_q) && (track_tab_q[i] == tid_s1);
			t_idx    = t_idx | (t_hit[i] ? TIDX_W'(i) : '0);
		end
		p_idx = '0;
		for (int j = 0; j < MAX_PLOTS; j++) begin
			p_hit[j] = (PCNT_W'(j) < plot_count_q) && (plot_tab_q[j] == pid_s1);
			p_idx    = p_idx | (p_hit[j] ? PIDX_W'(j) : '0);
		end
	end

	assign t_miss = ~|t_hit;
	assign p_miss = ~|p_hit;
	assign t_full = track_count_q == TCNT_W'(MAX_TRACKS);
	assign p_full = plot_count_q == PCNT_W'(MAX_PLOTS);

	assign busy   = hold || (valid_s1 && q_full);
	assign accept = start && !busy;
	assign push   = valid_s1 && !q_full;

	always_comb begin
		cmd      = '0;
		cmd.gain = gain_s1;
		cmd.flag = flag_s1;
		t_ins    = 1'b0;
		p_ins    = 1'b0;
		cnt_clr  = 1'b0;
		unique case (op_s1)
			OP_ASSOC: begin
				priority if (t_miss && t_full) begin
					cmd.status = STAT_TFULL;
				end else if (p_miss && p_full) begin
					cmd.status = STAT_PFULL;
				end else begin
					cmd.kind = KIND_WRITE;
					t_ins    = t_miss;
					p_ins    = p_miss;
					cmd.tidx = t_miss ? track_count_q[TIDX_W-1:0] : t_idx;
					cmd.pidx = p_miss ? plot_count_q[PIDX_W-1:0] : p_idx;
				end
			end
			OP_CLEAR: begin
				cmd.kind = KIND_CLEAR;
				cnt_clr  = 1'b1;
			end
			OP_READ: begin
				if (t_miss || p_miss) begin
					cmd.status = STAT_MISS;
				end else begin
					cmd.kind = KIND_READ;
					cmd.tidx = t_idx;
					cmd.pidx = p_idx;
				end
			end
			default: begin
				cmd.kind = KIND_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			track_count_q <= '0;
			plot_count_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
			if (push) begin
				if (cnt_clr) begin
					track_count_q <= '0;
					plot_count_q  <= '0;
				end else begin
					if (t_ins) begin
						track_count_q <= track_count_q + 1'b1;
					end
					if (p_ins) begin
						plot_count_q <= plot_count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= operation;
			tid_s1  <= track_id[ID_WIDTH-1:0];
			pid_s1  <= plot_id[ID_WIDTH-1:0];
			flag_s1 <= in_gate;
			gain_s1 <= gain[GAIN_BITS-1:0];
		end
		if (push && t_ins) begin
			track_tab_q[track_count_q[TIDX_W-1:0]] <= tid_s1;
		end
		if (push && p_ins) begin
			plot_tab_q[plot_count_q[PIDX_W-1:0]] <= pid_s1;
		end
	end

endmodule

// ----- sv/tpat_queue.sv -----
module tpat_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tpat_pkg::cmd_t din,
	input  logic           pop,
	output tpat_pkg::cmd_t dout,
	output logic           avail,
	output logic           full
);

	import tpat_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign avail = count_q != '0;
	assign full  = count_q == QCNT_W'(QDEPTH);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ----- sv/tpat_back.sv -----
module tpat_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           avail,
	input  tpat_pkg::cmd_t head,
	output logic           pop,
	output logic           init_hold,
	output logic           done,
	output tpat_pkg::res_t res
);

	import tpat_pkg::*;

	localparam logic [1:0] BK_IDLE  = 2'd0;
	localparam logic [1:0] BK_READ  = 2'd1;
	localparam logic [1:0] BK_SWEEP = 2'd2;

	logic [1:0]        state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic              report_q;
	logic              done_q;
	res_t              res_q;
	logic [TIDX_W-1:0] tidx_q;
	logic [PIDX_W-1:0] pidx_q;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]  cell_addr;
	logic [ENTRY_W-1:0] ram_rdata;
	logic               sweeping, sweep_last, direct;

	assign sweeping   = state_q == BK_SWEEP;
	assign sweep_last = sweep_q == ADDR_W'(CELLS - 1);
	assign pop        = avail && (state_q == BK_IDLE);
	assign direct     = pop && (head.kind == KIND_NONE || head.kind == KIND_WRITE);
	assign init_hold  = sweeping && !report_q;
	assign cell_addr  = ADDR_W'(head.tidx) * ADDR_W'(MAX_PLOTS) + ADDR_W'(head.pidx);

	assign ram_we    = sweeping || (pop && head.kind == KIND_WRITE);
	assign ram_waddr = sweeping ? sweep_q : cell_addr;
	assign ram_wdata = sweeping ? '0 : {head.gain, head.flag};

	tpat_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CELLS)
	) u_matrix (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cell_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_SWEEP;
			sweep_q  <= '0;
			report_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				BK_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							KIND_READ: begin
								state_q <= BK_READ;
							end
							KIND_CLEAR: begin
								state_q  <= BK_SWEEP;
								sweep_q  <= '0;
								report_q <= 1'b1;
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				BK_READ: begin
					done_q  <= 1'b1;
					state_q <= BK_IDLE;
				end
				BK_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_last) begin
						state_q  <= BK_IDLE;
						done_q   <= report_q;
						report_q <= 1'b0;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tidx_q <= head.tidx;
			pidx_q <= head.pidx;
		end
		priority if (direct) begin
			res_q.tidx   <= PORT_TIDX_W'(head.tidx);
			res_q.pidx   <= PORT_PIDX_W'(head.pidx);
			res_q.status <= head.status;
			res_q.gain   <= '0;
			res_q.flag   <= 1'b0;
		end else if (state_q == BK_READ) begin
			res_q.tidx   <= PORT_TIDX_W'(tidx_q);
			res_q.pidx   <= PORT_PIDX_W'(pidx_q);
			res_q.status <= STAT_OK;
			res_q.gain   <= PORT_GAIN_W'(ram_rdata[ENTRY_W-1:1]);
			res_q.flag   <= ram_rdata[0];
		end else if (sweeping && sweep_last) begin
			res_q <= '0;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sv/tpat_checker.sv -----
module tpat_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic                               done,
	input logic [tpat_pkg::PORT_TIDX_W-1:0]   track_index,
	input logic [tpat_pkg::PORT_PIDX_W-1:0]   plot_index,
	input logic [1:0]                         status,
	input logic [tpat_pkg::PORT_GAIN_W-1:0]   gain_out,
	input logic                               in_gate_out
);

	import tpat_pkg::*;

	logic [3:0] pending_q;
	logic       accept;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (accept && !done) begin
			pending_q <= pending_q + 1'b1;
		end else if (done && !accept) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> pending_q != '0)
		else $error("result without an outstanding transaction");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pending_q == '0) |=> !done)
		else $error("result one cycle after acceptance");

	a_error_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == STAT_MISS || status == STAT_TFULL || status == STAT_PFULL))
		|-> (track_index == '0 && plot_index == '0 && gain_out == '0 && !in_gate_out))
		else $error("error result with non-zero fields");

	a_busy_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> busy)
		else $error("accepting during reset sweep");

endmodule

bind track_plot_association_table_core tpat_checker u_tpat_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.track_index (track_index),
	.plot_index  (plot_index),
	.status      (status),
	.gain_out    (gain_out),
	.in_gate_out (in_gate_out)
);
